@@ rtl/core/thermostat_mode_controller_defines.svh @@
// Assertion macros shared by the thermostat controller RTL.
`ifndef THERMOSTAT_MODE_CONTROLLER_DEFINES_SVH
`define THERMOSTAT_MODE_CONTROLLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TMC_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("thermostat invariant violated");
`define TMC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("thermostat sequence violated");
`else
`define TMC_ASSERT_ALWAYS(lbl, expr)
`define TMC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/tmc_pkg.sv @@
// Types, codes and constants shared by the thermostat controller modules.
`default_nettype none
package tmc_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BUTTON_W   = 2;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SP_W       = 7;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned BAND_W     = 5;
  localparam int unsigned EDIT_W     = 8;
  localparam int unsigned BLINK_W    = 6;
  localparam int unsigned TEMP_W     = 9;
  localparam int unsigned DRV_W      = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 32;

  localparam int unsigned TEMP_SCALE = 500;
  localparam int unsigned TEMP_MAX   = 499;

  localparam int unsigned WINDOW_DEFAULT   = 10;
  localparam int unsigned ADC_BITS_DEFAULT = 10;

  localparam logic [SP_W-1:0]    SET_MIN_RST      = 7'd35;
  localparam logic [SP_W-1:0]    SET_MAX_RST      = 7'd75;
  localparam logic [STEP_W-1:0]  SET_STEP_RST     = 4'd5;
  localparam logic [BAND_W-1:0]  BAND_RST         = 5'd5;
  localparam logic [EDIT_W-1:0]  EDIT_TIMEOUT_RST = 8'd100;
  localparam logic [BLINK_W-1:0] BLINK_RELOAD_RST = 6'd20;
  localparam logic [SP_W-1:0]    SETPOINT_RST     = 7'd60;
  localparam logic [EDIT_W-1:0]  EDIT_COUNT_RST   = 8'd50;
  localparam logic [BLINK_W-1:0] BLINK_COUNT_RST  = 6'd21;

  typedef enum logic [KIND_W-1:0] {
    EV_TICK   = 2'd0,
    EV_BUTTON = 2'd1,
    EV_SAMPLE = 2'd2
  } tmc_event_t;

  typedef enum logic [BUTTON_W-1:0] {
    BTN_POWER = 2'd0,
    BTN_UP    = 2'd1,
    BTN_DOWN  = 2'd2
  } tmc_button_t;

  typedef enum logic [2:0] {
    ST_OFF  = 3'b001,
    ST_WORK = 3'b010,
    ST_EDIT = 3'b100
  } tmc_mode_t;

  localparam logic [MODE_W-1:0] MODE_OFF  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WORK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_EDIT = 2'd2;

  typedef enum logic [DRV_W-1:0] {
    DRV_NONE = 2'd0,
    DRV_HEAT = 2'd1,
    DRV_COOL = 2'd2
  } tmc_drive_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_MIN      = 3'd0,
    CFG_SET_MAX      = 3'd1,
    CFG_SET_STEP     = 3'd2,
    CFG_BAND         = 3'd3,
    CFG_EDIT_TIMEOUT = 3'd4,
    CFG_BLINK_RELOAD = 3'd5
  } tmc_cfg_idx_t;

  // Ring control from the mode logic to the averaging unit.
  typedef struct packed {
    logic push;
    logic clear;
  } tmc_ring_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/tmc_ring_avg.sv @@
// Reading ring with running sum and constant-reciprocal average.
`default_nettype none
`include "thermostat_mode_controller_defines.svh"
module tmc_ring_avg #(
  parameter int unsigned WINDOW = tmc_pkg::WINDOW_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tmc_pkg::tmc_ring_ctl_t        ctl,
  input  wire logic [tmc_pkg::TEMP_W-1:0]    temp,
  output logic [tmc_pkg::TEMP_W+$clog2(WINDOW)-1:0] sum_next,
  output logic [tmc_pkg::TEMP_W-1:0]         avg_next
);

  localparam int unsigned POS_W  = $clog2(WINDOW);
  localparam int unsigned SUM_W  = tmc_pkg::TEMP_W + POS_W;
  localparam int unsigned SHIFT  = SUM_W + 5;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned RECIP_W = SHIFT + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;

  logic [tmc_pkg::TEMP_W-1:0] ring [WINDOW];
  logic [POS_W-1:0]           pos;
  logic [SUM_W-1:0]           sum;
  logic [SUM_W:0]             sum_add;
  logic [PROD_W-1:0]          prod;

  always_comb begin
    sum_add = {1'b0, sum} + (SUM_W+1)'(temp) - (SUM_W+1)'(ring[pos]);
    if (ctl.clear) begin
      sum_next = '0;
    end else if (ctl.push) begin
      sum_next = sum_add[SUM_W-1:0];
    end else begin
      sum_next = sum;
    end
    // Floor division by the window length through a scaled reciprocal.
    prod     = PROD_W'(sum_next) * PROD_W'(RECIP);
    avg_next = prod[SHIFT +: tmc_pkg::TEMP_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      sum <= '0;
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
    end else begin
      sum <= sum_next;
      if (ctl.clear) begin
        for (int i = 0; i < WINDOW; i++) begin
          ring[i] <= '0;
        end
      end else if (ctl.push) begin
        ring[pos] <= temp;
        pos <= (pos == POS_W'(WINDOW - 1)) ? '0 : pos + 1'b1;
      end
    end
  end

  `TMC_ASSERT_NEXT(a_clear_empties_sum, ctl.clear, sum == '0)
  `TMC_ASSERT_ALWAYS(a_pos_in_window, pos <= POS_W'(WINDOW - 1))
  `TMC_ASSERT_ALWAYS(a_sum_bounded, sum <= SUM_W'(WINDOW * tmc_pkg::TEMP_MAX))

endmodule
`default_nettype wire

@@ rtl/core/thermostat_mode_controller.sv @@
// Top level of the heater thermostat: event stream in, status word out.
`default_nettype none
`include "thermostat_mode_controller_defines.svh"
// The thermostat takes one event word per clock cycle unless m_tready holds
// back the status stream, and returns exactly one status word for each. An
// event is a 50 ms tick, a button press or a raw temperature sample, selected
// by s_tuser. An accepted word is scaled to degrees on its way into the input
// register; from there, once the output register is free or being emptied,
// the mode logic and the averaging unit update all state together and load
// the status word into the output register, which raises m_tvalid. The rate
// of one word per cycle is set by the state update loop: the running sum of
// the reading ring is updated and compared against the setpoint band in the
// same cycle, so each event sees everything the previous one left behind.
// While a status word is held by m_tready low, one more event waits in the
// input register before s_tready drops. The status reports the state after
// the event. The configuration registers (setpoint limits, step, band, edit
// timeout and blink reload) are written through cfg_we/cfg_index/cfg_data and
// take effect on the next event; writes to indexes six and seven are dropped.
module thermostat_mode_controller #(
  parameter int unsigned WINDOW   = tmc_pkg::WINDOW_DEFAULT,
  parameter int unsigned ADC_BITS = tmc_pkg::ADC_BITS_DEFAULT
) (
  input  wire logic clk,
  input  wire logic rst,
  // Event stream.
  input  wire logic s_tvalid,
  output logic      s_tready,
  // s_tdata, low bit up: button, adc_sample, zero fill.
  input  wire logic [((tmc_pkg::BUTTON_W + ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // s_tuser: req_type.
  input  wire logic [tmc_pkg::KIND_W-1:0] s_tuser,
  // Status stream.
  output logic      m_tvalid,
  input  wire logic m_tready,
  // m_tdata, low bit up: mode, setpoint, latest_temp, average_temp,
  // drive_state, heater_on, cooler_on, lamp_on.
  output logic [tmc_pkg::OUT_DATA_W-1:0] m_tdata,
  // Configuration write port.
  input  wire logic                            cfg_we,
  input  wire logic [tmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned SUM_W   = tmc_pkg::TEMP_W + $clog2(WINDOW);
  localparam int unsigned SCALE_W = ADC_BITS + tmc_pkg::TEMP_W;

  // Configuration registers.
  logic [tmc_pkg::SP_W-1:0]    set_min;
  logic [tmc_pkg::SP_W-1:0]    set_max;
  logic [tmc_pkg::STEP_W-1:0]  set_step;
  logic [tmc_pkg::BAND_W-1:0]  band;
  logic [tmc_pkg::EDIT_W-1:0]  edit_timeout;
  logic [tmc_pkg::BLINK_W-1:0] blink_reload;

  // Input register.
  logic                         in_valid;
  logic [tmc_pkg::KIND_W-1:0]   in_kind;
  logic [tmc_pkg::BUTTON_W-1:0] in_button;
  logic [tmc_pkg::TEMP_W-1:0]   in_temp;
  logic [SCALE_W-1:0]           scale_prod;
  logic                         s_fire;
  logic                         fire;

  // Controller state.
  tmc_pkg::tmc_mode_t          mode_reg, mode_next;
  logic [tmc_pkg::SP_W-1:0]    active_setpoint, active_setpoint_next;
  logic [tmc_pkg::SP_W-1:0]    saved_setpoint, saved_setpoint_next;
  logic [tmc_pkg::EDIT_W-1:0]  edit_count, edit_count_next;
  logic [tmc_pkg::BLINK_W-1:0] blink_count, blink_count_next;
  logic [tmc_pkg::TEMP_W-1:0]  last_temp, last_temp_next;
  tmc_pkg::tmc_drive_t         drive_mode, drive_mode_next;
  logic heater, heater_next;
  logic cooler, cooler_next;
  logic lamp, lamp_next;

  // Setpoint stepping and band compare.
  logic [tmc_pkg::SP_W:0]      sp_up;
  logic [tmc_pkg::SP_W:0]      sp_down_limit;
  logic [tmc_pkg::SP_W:0]      hi_base;
  logic [tmc_pkg::SP_W-1:0]    lo_base;
  logic [SUM_W-1:0]            hi_thr;
  logic [SUM_W-1:0]            lo_thr;
  logic [tmc_pkg::MODE_W-1:0]  mode_code;

  tmc_pkg::tmc_ring_ctl_t      ring_ctl;
  logic [SUM_W-1:0]            sum_next;
  logic [tmc_pkg::TEMP_W-1:0]  avg_next;

  // Handshake: the input register advances when the output register is free
  // or is being emptied in the same cycle.
  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;
  assign s_fire   = s_tvalid && s_tready;

  // Degrees = adc * 500 / 2^ADC_BITS, done before the input register.
  assign scale_prod = SCALE_W'(s_tdata[tmc_pkg::BUTTON_W +: ADC_BITS]) *
                      SCALE_W'(tmc_pkg::TEMP_SCALE);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_kind   <= s_tuser;
      in_button <= s_tdata[tmc_pkg::BUTTON_W-1:0];
      in_temp   <= scale_prod[ADC_BITS +: tmc_pkg::TEMP_W];
    end
  end

  tmc_ring_avg #(
    .WINDOW (WINDOW)
  ) u_ring_avg (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ring_ctl),
    .temp     (in_temp),
    .sum_next (sum_next),
    .avg_next (avg_next)
  );

  // Ring control: a reading taken in working mode is pushed, and a power
  // press that turns the block off clears the ring. Without a word to process
  // nothing may touch the ring.
  always_comb begin
    ring_ctl = '0;
    if (fire) begin
      if ((in_kind == tmc_pkg::EV_SAMPLE) && (mode_reg == tmc_pkg::ST_WORK)) begin
        ring_ctl.push = 1'b1;
      end
      if ((in_kind == tmc_pkg::EV_BUTTON) && (in_button == tmc_pkg::BTN_POWER) &&
          (mode_reg != tmc_pkg::ST_OFF)) begin
        ring_ctl.clear = 1'b1;
      end
    end
  end

  // Band thresholds on the sum side, so no division sits in the compare:
  // avg > sp + band  <=>  sum >= (sp + band + 1) * WINDOW
  // avg < sp - band  <=>  sum <  (sp - band) * WINDOW, only when sp > band.
  always_comb begin
    sp_up         = {1'b0, active_setpoint} + (tmc_pkg::SP_W+1)'(set_step);
    sp_down_limit = {1'b0, set_min} + (tmc_pkg::SP_W+1)'(set_step);
    hi_base       = {1'b0, active_setpoint} + (tmc_pkg::SP_W+1)'(band) + 1'b1;
    lo_base       = active_setpoint - tmc_pkg::SP_W'(band);
    hi_thr        = SUM_W'(hi_base * WINDOW);
    lo_thr        = SUM_W'(lo_base * WINDOW);
  end

  // Event handling.
  always_comb begin
    mode_next            = mode_reg;
    active_setpoint_next = active_setpoint;
    saved_setpoint_next  = saved_setpoint;
    edit_count_next      = edit_count;
    blink_count_next     = blink_count;
    last_temp_next       = last_temp;
    drive_mode_next      = drive_mode;
    heater_next          = heater;
    cooler_next          = cooler;
    lamp_next            = lamp;

    case (in_kind)
      tmc_pkg::EV_TICK: begin
        if (mode_reg == tmc_pkg::ST_EDIT) begin
          if (edit_count == '0) begin
            edit_count_next     = edit_timeout;
            mode_next           = tmc_pkg::ST_WORK;
            saved_setpoint_next = active_setpoint;
          end else begin
            edit_count_next = edit_count - 1'b1;
          end
        end
        if (blink_count == '0) begin
          blink_count_next = blink_reload;
          if (drive_mode == tmc_pkg::DRV_HEAT) begin
            lamp_next = !lamp;
          end
        end else begin
          blink_count_next = blink_count - 1'b1;
        end
      end
      tmc_pkg::EV_BUTTON: begin
        unique case (in_button) inside
          tmc_pkg::BTN_POWER: begin
            if (mode_reg == tmc_pkg::ST_OFF) begin
              mode_next            = tmc_pkg::ST_WORK;
              active_setpoint_next = saved_setpoint;
            end else begin
              // Power down drops the drives and forgets the readings.
              mode_next       = tmc_pkg::ST_OFF;
              heater_next     = 1'b0;
              cooler_next     = 1'b0;
              lamp_next       = 1'b0;
              drive_mode_next = tmc_pkg::DRV_NONE;
            end
          end
          tmc_pkg::BTN_UP, tmc_pkg::BTN_DOWN: begin
            if (mode_reg == tmc_pkg::ST_WORK) begin
              mode_next       = tmc_pkg::ST_EDIT;
              edit_count_next = edit_timeout;
            end else if (mode_reg == tmc_pkg::ST_EDIT) begin
              edit_count_next = edit_timeout;
              if (in_button == tmc_pkg::BTN_UP) begin
                active_setpoint_next = (sp_up > {1'b0, set_max}) ?
                                       set_max : sp_up[tmc_pkg::SP_W-1:0];
              end else begin
                active_setpoint_next = ({1'b0, active_setpoint} < sp_down_limit) ?
                                       set_min :
                                       active_setpoint - tmc_pkg::SP_W'(set_step);
              end
            end
          end
          default: begin
          end
        endcase
      end
      tmc_pkg::EV_SAMPLE: begin
        if (mode_reg == tmc_pkg::ST_WORK) begin
          last_temp_next = in_temp;
          if (sum_next >= hi_thr) begin
            heater_next     = 1'b0;
            cooler_next     = 1'b1;
            lamp_next       = 1'b1;
            drive_mode_next = tmc_pkg::DRV_COOL;
          end else if ((active_setpoint > tmc_pkg::SP_W'(band)) && (sum_next < lo_thr)) begin
            heater_next     = 1'b1;
            cooler_next     = 1'b0;
            drive_mode_next = tmc_pkg::DRV_HEAT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (mode_next)
      tmc_pkg::ST_OFF:  mode_code = tmc_pkg::MODE_OFF;
      tmc_pkg::ST_WORK: mode_code = tmc_pkg::MODE_WORK;
      tmc_pkg::ST_EDIT: mode_code = tmc_pkg::MODE_EDIT;
      default:          mode_code = tmc_pkg::MODE_OFF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= tmc_pkg::ST_OFF;
      active_setpoint <= tmc_pkg::SETPOINT_RST;
      saved_setpoint  <= tmc_pkg::SETPOINT_RST;
      edit_count      <= tmc_pkg::EDIT_COUNT_RST;
      blink_count     <= tmc_pkg::BLINK_COUNT_RST;
      last_temp       <= '0;
      drive_mode      <= tmc_pkg::DRV_COOL;
      heater          <= 1'b0;
      cooler          <= 1'b0;
      lamp            <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (fire) begin
        mode_reg        <= mode_next;
        active_setpoint <= active_setpoint_next;
        saved_setpoint  <= saved_setpoint_next;
        edit_count      <= edit_count_next;
        blink_count     <= blink_count_next;
        last_temp       <= last_temp_next;
        drive_mode      <= drive_mode_next;
        heater          <= heater_next;
        cooler          <= cooler_next;
        lamp            <= lamp_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {lamp_next, cooler_next, heater_next, drive_mode_next, avg_next,
                  last_temp_next, active_setpoint_next, mode_code};
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_min      <= tmc_pkg::SET_MIN_RST;
      set_max      <= tmc_pkg::SET_MAX_RST;
      set_step     <= tmc_pkg::SET_STEP_RST;
      band         <= tmc_pkg::BAND_RST;
      edit_timeout <= tmc_pkg::EDIT_TIMEOUT_RST;
      blink_reload <= tmc_pkg::BLINK_RELOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tmc_pkg::CFG_SET_MIN:      set_min      <= cfg_data[tmc_pkg::SP_W-1:0];
        tmc_pkg::CFG_SET_MAX:      set_max      <= cfg_data[tmc_pkg::SP_W-1:0];
        tmc_pkg::CFG_SET_STEP:     set_step     <= cfg_data[tmc_pkg::STEP_W-1:0];
        tmc_pkg::CFG_BAND:         band         <= cfg_data[tmc_pkg::BAND_W-1:0];
        tmc_pkg::CFG_EDIT_TIMEOUT: edit_timeout <= cfg_data[tmc_pkg::EDIT_W-1:0];
        tmc_pkg::CFG_BLINK_RELOAD: blink_reload <= cfg_data[tmc_pkg::BLINK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `TMC_ASSERT_ALWAYS(a_no_heat_and_cool, !(heater && cooler))
  `TMC_ASSERT_ALWAYS(a_heater_means_heating, !heater || (drive_mode == tmc_pkg::DRV_HEAT))
  `TMC_ASSERT_ALWAYS(a_off_drives_idle,
                     (mode_reg != tmc_pkg::ST_OFF) || (!heater && !cooler))
  `TMC_ASSERT_NEXT(a_fire_loads_result, fire, m_tvalid)
  `TMC_ASSERT_NEXT(a_held_word_stable, in_valid && !fire,
                   in_valid && $stable(in_temp) && $stable(in_kind))

endmodule
`default_nettype wire
